@@ sv/fsc_pkg.sv @@
package fsc_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int PLANE_COUNT   = 6;
    localparam int COMP_COUNT    = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT_STEPS    = VALUE_WIDTH;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_TEST  = 1'b1;
    localparam logic [1:0] LAST_COL = 2'd3;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_BUILD = 9'b000000010,
        ST_SQ    = 9'b000000100,
        ST_SQRT  = 9'b000001000,
        ST_DIV   = 9'b000010000,
        ST_STORE = 9'b000100000,
        ST_TEST  = 9'b001000000,
        ST_TSUM  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic       load;
        logic       test_start;
        logic       build;
        logic       sq_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_end;
        logic       store;
        logic       issue;
        logic       out_load;
        logic [2:0] plane;
        logic [1:0] sq_idx;
        logic [1:0] comp;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    // row combined with w for each plane: left/right x, top/bottom y, back/front z
    function automatic logic [1:0] plane_row(input logic [2:0] p);
        logic [1:0] r;
        case (p) inside
            3'd0, 3'd1: r = 2'd0;
            3'd2, 3'd3: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic plane_neg(input logic [2:0] p);
        logic n;
        case (p) inside
            3'd1, 3'd2, 3'd5: n = 1'b1;
            default:          n = 1'b0;
        endcase
        return n;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] mag(input value_t v);
        return v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic value_t sat_wide(input logic signed [VALUE_WIDTH:0] v);
        value_t r;
        if (v[VALUE_WIDTH] != v[VALUE_WIDTH-1]) begin
            r = v[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                               : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end else begin
            r = v[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/fsc_ctrl.sv @@
module fsc_ctrl
    import fsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_operation,
    input  logic [1:0] s_column_index,
    input  stat_t      stat,
    output logic       s_ready,
    output cmd_t       cmd
);

    localparam int DIV_STEPS = VALUE_WIDTH + FRAC_BITS;
    localparam int MAX_STEPS = (DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS + 2);

    state_t           state_reg, state_next;
    logic [2:0]       plane_reg, plane_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       comp_reg, comp_next;

    always_comb begin
        state_next = state_reg;
        plane_next = plane_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.plane  = plane_reg;
        cmd.sq_idx = cnt_reg[1:0];
        cmd.comp   = comp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cnt_next = '0;
                    if (s_operation == OP_LOAD) begin
                        cmd.load = 1'b1;
                        if (s_column_index == LAST_COL) begin
                            plane_next = '0;
                            state_next = ST_BUILD;
                        end
                    end else begin
                        cmd.test_start = 1'b1;
                        state_next     = ST_TEST;
                    end
                end
            end
            ST_BUILD: begin
                cmd.build  = 1'b1;
                cnt_next   = '0;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == CNT_W'(3)) begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                if (cnt_reg == '0) cmd.sqrt_init = 1'b1;
                else               cmd.sqrt_step = 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS)) begin
                    cnt_next   = '0;
                    comp_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end else if (cnt_reg == CNT_W'(DIV_STEPS + 1)) begin
                    cmd.div_end = 1'b1;
                    cnt_next    = '0;
                    if (comp_reg == 2'd3) state_next = ST_STORE;
                    else                  comp_next  = comp_reg + 1'b1;
                end else begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (plane_reg == 3'(PLANE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    plane_next = plane_reg + 1'b1;
                    state_next = ST_BUILD;
                end
            end
            ST_TEST: begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PLANE_COUNT - 1)) state_next = ST_TSUM;
            end
            ST_TSUM: state_next = ST_OUT;
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !stat.out_free) |=> state_reg == ST_OUT)
        else $error("result dropped while output busy");
    a_store_after_last_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STORE |-> comp_reg == 2'd3)
        else $error("plane stored before all components divided");
    a_test_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == OP_TEST) |=> state_reg == ST_TEST)
        else $error("test transfer did not start test");
`endif

endmodule

@@ sv/fsc_datapath.sv @@
module fsc_datapath
    import fsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  s_column_index,
    input  value_t      s_column_x,
    input  value_t      s_column_y,
    input  value_t      s_column_z,
    input  value_t      s_column_w,
    input  value_t      s_centre_x,
    input  value_t      s_centre_y,
    input  value_t      s_centre_z,
    input  logic [30:0] s_sphere_radius,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_inside_res
);

    localparam int VW = VALUE_WIDTH;
    localparam int NW = VW + FRAC_BITS;
    localparam int DW = VW + 4;

    // Q multiply: truncate toward zero, saturate
    function automatic value_t mul_q(input value_t a, input value_t b);
        logic [2*VW-1:0] p;
        logic [2*VW-1:0] q;
        logic [2*VW-1:0] lim;
        logic            neg;
        p   = {{VW{1'b0}}, mag(a)} * {{VW{1'b0}}, mag(b)};
        q   = p >> FRAC_BITS;
        neg = a[VW-1] ^ b[VW-1];
        lim = neg ? (2*VW)'({1'b1, {(VW-1){1'b0}}}) : (2*VW)'({(VW-1){1'b1}});
        if (q > lim) q = lim;
        return neg ? (~q[VW-1:0] + 1'b1) : q[VW-1:0];
    endfunction

    value_t              mat_reg   [4][4];
    value_t              ring_reg  [PLANE_COUNT][COMP_COUNT];
    value_t              c_reg     [COMP_COUNT];
    value_t              newp_reg  [COMP_COUNT];
    logic [2*VW-1:0]     prod_reg;
    logic [2*VW-1:0]     acc_reg;
    logic [2*VW-1:0]     rad_reg;
    logic [VW+3:0]       srem_reg;
    logic [VW-1:0]       root_reg;
    logic [NW-1:0]       nq_reg;
    logic [VW:0]         drem_reg;
    logic                dneg_reg;
    value_t              cen_reg   [3];
    logic [30:0]         radius_reg;
    value_t              tprod_reg [3];
    value_t              tw_reg;
    logic                tv_reg;
    logic                res_reg;
    logic                m_valid_reg;
    logic                inside_reg;

    logic [1:0]          row;
    logic                rneg;
    value_t              c_next    [COMP_COUNT];
    logic [VW+3:0]       srem_t;
    logic [VW+3:0]       strial;
    logic [VW:0]         drem_t;
    logic                dge;
    logic [NW-1:0]       qlim;
    logic [NW-1:0]       qsat;
    value_t              qval;
    value_t              newplane  [COMP_COUNT];
    logic signed [DW-1:0] dsum;

    always_comb begin
        row  = plane_row(cmd.plane);
        rneg = plane_neg(cmd.plane);
        for (int k = 0; k < COMP_COUNT; k++) begin
            c_next[k] = sat_wide(rneg
                ? {mat_reg[k][3][VW-1], mat_reg[k][3]} - {mat_reg[k][row][VW-1], mat_reg[k][row]}
                : {mat_reg[k][3][VW-1], mat_reg[k][3]} + {mat_reg[k][row][VW-1], mat_reg[k][row]});
            newplane[k] = (root_reg == '0) ? '0 : newp_reg[k];
        end
        srem_t = {srem_reg[VW+1:0], rad_reg[2*VW-1 -: 2]};
        strial = {2'b00, root_reg, 2'b01};
        drem_t = {drem_reg[VW-1:0], nq_reg[NW-1]};
        dge    = drem_t >= {1'b0, root_reg};
        qlim   = dneg_reg ? NW'({1'b1, {(VW-1){1'b0}}}) : NW'({(VW-1){1'b1}});
        qsat   = (nq_reg > qlim) ? qlim : nq_reg;
        qval   = dneg_reg ? (~qsat[VW-1:0] + 1'b1) : qsat[VW-1:0];
        dsum   = DW'(tprod_reg[0]) + DW'(tprod_reg[1]) + DW'(tprod_reg[2]) + DW'(tw_reg)
               + $signed({{(DW-31){1'b0}}, radius_reg});
    end

    // matrix, plane ring, test flags: reset to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++)
                for (int k = 0; k < 4; k++) mat_reg[i][k] <= '0;
            for (int i = 0; i < PLANE_COUNT; i++)
                for (int k = 0; k < COMP_COUNT; k++) ring_reg[i][k] <= '0;
            tv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                mat_reg[s_column_index][0] <= s_column_x;
                mat_reg[s_column_index][1] <= s_column_y;
                mat_reg[s_column_index][2] <= s_column_z;
                mat_reg[s_column_index][3] <= s_column_w;
            end
            if (cmd.store || cmd.issue) begin
                for (int i = 0; i < PLANE_COUNT - 1; i++) ring_reg[i] <= ring_reg[i+1];
                if (cmd.store) ring_reg[PLANE_COUNT-1] <= newplane;
                else           ring_reg[PLANE_COUNT-1] <= ring_reg[0];
            end
            tv_reg <= cmd.issue;
            if (cmd.out_load)  m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.build) begin
            c_reg   <= c_next;
            acc_reg <= '0;
        end
        if (cmd.sq_step) begin
            prod_reg <= {{VW{1'b0}}, mag(c_reg[cmd.sq_idx])}
                      * {{VW{1'b0}}, mag(c_reg[cmd.sq_idx])};
            if (cmd.sq_idx != 2'd0) acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= acc_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            rad_reg <= rad_reg << 2;
            if (srem_t >= strial) begin
                srem_reg <= srem_t - strial;
                root_reg <= {root_reg[VW-2:0], 1'b1};
            end else begin
                srem_reg <= srem_t;
                root_reg <= {root_reg[VW-2:0], 1'b0};
            end
        end
        if (cmd.div_init) begin
            nq_reg   <= NW'(mag(c_reg[cmd.comp])) << FRAC_BITS;
            drem_reg <= '0;
            dneg_reg <= c_reg[cmd.comp][VW-1];
        end
        if (cmd.div_step) begin
            nq_reg   <= {nq_reg[NW-2:0], dge};
            drem_reg <= dge ? (drem_t - {1'b0, root_reg}) : drem_t;
        end
        if (cmd.div_end) newp_reg[cmd.comp] <= qval;
        if (cmd.test_start) begin
            cen_reg[0] <= s_centre_x;
            cen_reg[1] <= s_centre_y;
            cen_reg[2] <= s_centre_z;
            radius_reg <= s_sphere_radius;
            res_reg    <= 1'b1;
        end else if (tv_reg && (dsum[DW-1] || dsum == '0)) begin
            res_reg <= 1'b0;
        end
        if (cmd.issue) begin
            for (int k = 0; k < 3; k++) tprod_reg[k] <= mul_q(ring_reg[0][k], cen_reg[k]);
            tw_reg <= ring_reg[0][3];
        end
        if (cmd.out_load) inside_reg <= res_reg;
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_inside_res  = inside_reg;

endmodule

@@ sv/frustum_sphere_cull_unit.sv @@
// Frustum sphere culler, signed Q(32-FRAC_BITS).FRAC_BITS. An item with operation 0
// writes one column of the view-projection matrix and returns nothing; column 3
// (send it last) also rebuilds the six planes (w row plus or minus the x, y, z rows,
// each divided by the floor square root of its normal's squared length; a zero
// length plane is all zero). During a rebuild s_ready is low; how long depends on
// the one-bit-per-cycle square root and the shared restoring divider run four times
// per plane. An item with operation 1 tests a sphere and returns one m_inside_res
// transfer (1 = inside; a sphere that only touches a plane gives 0); it passes one
// plane per cycle through three registered multipliers and a sum/compare stage,
// and s_ready returns after the result is loaded into the output register, so a
// result may wait on m_ready while the next item is taken.
module frustum_sphere_cull_unit
    import fsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [1:0]  s_column_index,
    input  value_t      s_column_x,
    input  value_t      s_column_y,
    input  value_t      s_column_z,
    input  value_t      s_column_w,
    input  value_t      s_centre_x,
    input  value_t      s_centre_y,
    input  value_t      s_centre_z,
    input  logic [30:0] s_sphere_radius,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_inside_res
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: load/rebuild/test steps
    fsc_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_operation    (s_operation),
        .s_column_index (s_column_index),
        .stat           (stat),
        .s_ready        (s_ready),
        .cmd            (cmd)
    );

    // matrix, plane ring, sqrt/divide units, test multipliers, output register
    fsc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_column_index  (s_column_index),
        .s_column_x      (s_column_x),
        .s_column_y      (s_column_y),
        .s_column_z      (s_column_z),
        .s_column_w      (s_column_w),
        .s_centre_x      (s_centre_x),
        .s_centre_y      (s_centre_y),
        .s_centre_z      (s_centre_z),
        .s_sphere_radius (s_sphere_radius),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_inside_res    (m_inside_res)
    );

endmodule
